[design/rational_arith_unit_top_defines.svh]
// assertion macros used by the back end of the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_TOP_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RARU_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define RARU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/raru_pkg.sv]
// shared types, codes and constants of the rational arithmetic unit
`default_nettype none

package raru_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FIELD_BITS = 32;
  localparam int SHIFT_BITS = $clog2(WORD_BITS);
  localparam int CNT_BITS   = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0]         word_t;
  typedef logic signed [WORD_BITS-1:0]  sword_t;
  typedef logic signed [FIELD_BITS-1:0] field_t;
  typedef logic [SHIFT_BITS-1:0]        shift_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  // operation codes
  localparam logic [2:0] OP_MAKE = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_LT   = 3'd5;
  localparam logic [2:0] OP_EQ   = 3'd6;

  // error codes
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_ZDEN = 2'd1;
  localparam logic [1:0] ERR_DIVZ = 2'd2;

  // classified work item handed from front to back
  typedef struct packed {
    logic       build;
    word_t      num;
    word_t      den;
    logic       cmp;
    logic [1:0] err;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } qpkt_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_GCD, B_DIVN, B_DIVD} back_state_t;

endpackage

`default_nettype wire

[design/raru_front.sv]
// front end: captures a transaction, forms the wrapped products and classifies it
`default_nettype none

module raru_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            in_op,
  input  wire raru_pkg::field_t      in_a_num,
  input  wire raru_pkg::field_t      in_a_den,
  input  wire raru_pkg::field_t      in_b_num,
  input  wire raru_pkg::field_t      in_b_den,
  output raru_pkg::qpkt_t            push,
  input  wire logic                  q_full
);

  raru_pkg::front_state_t state_r, state_nxt;
  logic [1:0]      step_r, step_nxt;
  logic [2:0]      op_r;
  raru_pkg::word_t ap_r, aq_r, bp_r, bq_r;
  raru_pkg::word_t p0_r, p1_r, p2_r;
  raru_pkg::word_t mx, my, prod;
  raru_pkg::entry_t ent;
  logic            is_mul;

  assign busy   = (state_r != raru_pkg::F_IDLE);
  assign is_mul = (op_r == raru_pkg::OP_MUL);

  // one shared multiplier, operands picked per step
  always_comb begin
    case (step_r)
      2'd0: begin
        mx = ap_r;
        my = is_mul ? bp_r : bq_r;
      end
      2'd1: begin
        mx = is_mul ? aq_r : bp_r;
        my = is_mul ? bq_r : aq_r;
      end
      default: begin
        mx = aq_r;
        my = bq_r;
      end
    endcase
    prod = mx * my;
  end

  // classify the operation into a work item
  always_comb begin
    ent.build = 1'b0;
    ent.num   = '0;
    ent.den   = '0;
    ent.cmp   = 1'b0;
    ent.err   = raru_pkg::ERR_OK;
    unique case (op_r)
      raru_pkg::OP_MAKE: begin
        ent.build = 1'b1;
        ent.num   = ap_r;
        ent.den   = aq_r;
      end
      raru_pkg::OP_ADD: begin
        ent.build = 1'b1;
        ent.num   = p0_r + p1_r;
        ent.den   = p2_r;
      end
      raru_pkg::OP_SUB: begin
        ent.build = 1'b1;
        ent.num   = p0_r - p1_r;
        ent.den   = p2_r;
      end
      raru_pkg::OP_MUL: begin
        ent.build = 1'b1;
        ent.num   = p0_r;
        ent.den   = p1_r;
      end
      raru_pkg::OP_DIV: begin
        if (bp_r == '0) begin
          ent.err = raru_pkg::ERR_DIVZ;
        end else begin
          ent.build = 1'b1;
          ent.num   = p0_r;
          ent.den   = p1_r;
        end
      end
      raru_pkg::OP_LT: begin
        ent.cmp = ($signed(p0_r) < $signed(p1_r));
      end
      raru_pkg::OP_EQ: begin
        ent.cmp = (ap_r == bp_r) && (aq_r == bq_r);
      end
      default: begin
        ent.cmp = 1'b0;
      end
    endcase
    // zero denominator ends the item here
    if (ent.build && (ent.den == '0)) begin
      ent.build = 1'b0;
      ent.num   = '0;
      ent.err   = raru_pkg::ERR_ZDEN;
    end
  end

  // next state and queue push
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    push.valid = 1'b0;
    push.data  = ent;
    unique case (state_r)
      raru_pkg::F_IDLE: begin
        if (start) begin
          state_nxt = raru_pkg::F_MUL;
          step_nxt  = 2'd0;
        end
      end
      raru_pkg::F_MUL: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) begin
          state_nxt = raru_pkg::F_PUSH;
        end
      end
      raru_pkg::F_PUSH: begin
        if (!q_full) begin
          push.valid = 1'b1;
          state_nxt  = raru_pkg::F_IDLE;
        end
      end
      default: state_nxt = raru_pkg::F_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= raru_pkg::F_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // operand capture and product registers
  always_ff @(posedge clk) begin
    if ((state_r == raru_pkg::F_IDLE) && start) begin
      op_r <= in_op;
      ap_r <= raru_pkg::word_t'(raru_pkg::sword_t'(in_a_num));
      aq_r <= raru_pkg::word_t'(raru_pkg::sword_t'(in_a_den));
      bp_r <= raru_pkg::word_t'(raru_pkg::sword_t'(in_b_num));
      bq_r <= raru_pkg::word_t'(raru_pkg::sword_t'(in_b_den));
    end
    if (state_r == raru_pkg::F_MUL) begin
      case (step_r)
        2'd0:    p0_r <= prod;
        2'd1:    p1_r <= prod;
        default: p2_r <= prod;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/raru_queue.sv]
// two-entry queue between front end and back end
`default_nettype none

module raru_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire raru_pkg::qpkt_t push,
  output logic                 full,
  output raru_pkg::qpkt_t      head,
  input  wire logic            pop
);

  raru_pkg::entry_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.data  = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push.valid) wr_ptr_r <= ~wr_ptr_r;
      if (pop)        rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push.valid} - {1'b0, pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.data;
  end

endmodule

`default_nettype wire

[design/raru_back.sv]
// back end: binary gcd and two exact divisions, then the result strobe
`default_nettype none

`include "rational_arith_unit_top_defines.svh"

module raru_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire raru_pkg::qpkt_t head,
  output logic                 pop,
  output logic                 out_valid,
  output raru_pkg::field_t     out_res_num,
  output raru_pkg::field_t     out_res_den,
  output logic                 out_compare_true,
  output logic [1:0]           out_error_code
);

  localparam int W = raru_pkg::WORD_BITS;

  raru_pkg::back_state_t state_r, state_nxt;
  raru_pkg::word_t  u_r, u_nxt, v_r, v_nxt, g_r, g_nxt;
  raru_pkg::word_t  mp_r, mp_nxt, mq_r, mq_nxt;
  raru_pkg::word_t  quo_r, quo_nxt, rn_r, rn_nxt;
  logic [W:0]       rem_r, rem_nxt, rem_sh;
  raru_pkg::shift_t k_r, k_nxt;
  raru_pkg::cnt_t   cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt, ge;
  logic             out_valid_r, out_valid_nxt;
  raru_pkg::word_t  res_num_r, res_num_nxt, res_den_r, res_den_nxt;
  logic             cmp_r, cmp_nxt;
  logic [1:0]       err_r, err_nxt;
  raru_pkg::word_t  quo_step;

  function automatic raru_pkg::word_t mag(input raru_pkg::word_t v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  assign out_valid        = out_valid_r;
  assign out_res_num      = raru_pkg::field_t'(raru_pkg::sword_t'(res_num_r));
  assign out_res_den      = raru_pkg::field_t'(raru_pkg::sword_t'(res_den_r));
  assign out_compare_true = cmp_r;
  assign out_error_code   = err_r;

  // one restoring division step
  always_comb begin
    rem_sh   = {rem_r[W-1:0], quo_r[W-1]};
    ge       = (rem_sh >= {1'b0, g_r});
    quo_step = {quo_r[W-2:0], ge};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    g_nxt         = g_r;
    k_nxt         = k_r;
    mp_nxt        = mp_r;
    mq_nxt        = mq_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    rn_nxt        = rn_r;
    out_valid_nxt = 1'b0;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    cmp_nxt       = cmp_r;
    err_nxt       = err_r;
    pop           = 1'b0;
    unique case (state_r)
      raru_pkg::B_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.data.build) begin
            mp_nxt    = mag(head.data.num);
            mq_nxt    = mag(head.data.den);
            u_nxt     = mag(head.data.num);
            v_nxt     = mag(head.data.den);
            k_nxt     = '0;
            neg_nxt   = head.data.num[W-1] ^ head.data.den[W-1];
            state_nxt = raru_pkg::B_GCD;
          end else begin
            out_valid_nxt = 1'b1;
            res_num_nxt   = '0;
            res_den_nxt   = raru_pkg::word_t'(1);
            cmp_nxt       = head.data.cmp;
            err_nxt       = head.data.err;
          end
        end
      end
      raru_pkg::B_GCD: begin
        if (u_r == '0) begin
          g_nxt     = v_r << k_r;
          quo_nxt   = mp_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = raru_pkg::B_DIVN;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_r >= v_r) begin
          u_nxt = (u_r - v_r) >> 1;
        end else begin
          v_nxt = (v_r - u_r) >> 1;
        end
      end
      raru_pkg::B_DIVN: begin
        rem_nxt = ge ? (rem_sh - {1'b0, g_r}) : rem_sh;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == raru_pkg::cnt_t'(W - 1)) begin
          rn_nxt    = quo_step;
          quo_nxt   = mq_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = raru_pkg::B_DIVD;
        end
      end
      raru_pkg::B_DIVD: begin
        rem_nxt = ge ? (rem_sh - {1'b0, g_r}) : rem_sh;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == raru_pkg::cnt_t'(W - 1)) begin
          out_valid_nxt = 1'b1;
          res_num_nxt   = neg_r ? (~rn_r + 1'b1) : rn_r;
          res_den_nxt   = quo_step;
          cmp_nxt       = 1'b0;
          err_nxt       = raru_pkg::ERR_OK;
          state_nxt     = raru_pkg::B_IDLE;
        end
      end
      default: state_nxt = raru_pkg::B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= raru_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    g_r       <= g_nxt;
    k_r       <= k_nxt;
    mp_r      <= mp_nxt;
    mq_r      <= mq_nxt;
    neg_r     <= neg_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    rn_r      <= rn_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    cmp_r     <= cmp_nxt;
    err_r     <= err_nxt;
  end

  `RARU_ASSERT(a_err_zero_frac, clk, rst_n, out_valid_r && (err_r != raru_pkg::ERR_OK), (res_num_r == '0) && (res_den_r == raru_pkg::word_t'(1)), "error result not 0/1")
  `RARU_ASSERT(a_cmp_no_err, clk, rst_n, out_valid_r && cmp_r, err_r == raru_pkg::ERR_OK, "compare result with error")
  `RARU_ASSERT(a_gcd_v_nonzero, clk, rst_n, state_r == raru_pkg::B_GCD, v_r != '0, "gcd operand vanished")
  `RARU_ASSERT(a_pop_has_head, clk, rst_n, pop, head.valid, "pop from empty queue")
  `RARU_ASSERT_NEXT(a_gcd_to_div, clk, rst_n, (state_r == raru_pkg::B_GCD) && (u_r == '0), state_r == raru_pkg::B_DIVN, "gcd did not hand off")

endmodule

`default_nettype wire

[design/rational_arith_unit_top.sv]
// Rational arithmetic unit: make, add, subtract, multiply, divide, less-than and equal on
// 32-bit numerator/denominator fractions, results reduced by gcd with the sign on the
// numerator. A transaction is taken when start is high and busy is low; the front end
// forms the wrapped products on one shared multiplier, then hands the item to a two-entry
// queue, waiting while it is full, so busy drops while the back end still works. Each
// result appears for exactly one cycle with out_valid high and cannot be held off.
// Compare, error and odd-opcode items skip the reduction; a reduced fraction goes through
// binary gcd steps and then restoring division of numerator and denominator by the gcd,
// all in the single gcd/divide unit of the back end, which takes one item at a time.
`default_nettype none

module rational_arith_unit_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       in_op,
  input  wire logic signed [31:0] in_a_num,
  input  wire logic signed [31:0] in_a_den,
  input  wire logic signed [31:0] in_b_num,
  input  wire logic signed [31:0] in_b_den,
  output logic                  out_valid,
  output logic signed [31:0]    out_res_num,
  output logic signed [31:0]    out_res_den,
  output logic                  out_compare_true,
  output logic [1:0]            out_error_code
);

  raru_pkg::qpkt_t push, head;
  logic            q_full, pop;

  // accept and classify
  raru_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_op    (in_op),
    .in_a_num (in_a_num),
    .in_a_den (in_a_den),
    .in_b_num (in_b_num),
    .in_b_den (in_b_den),
    .push     (push),
    .q_full   (q_full)
  );

  // decoupling queue
  raru_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  // reduce and deliver
  raru_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_res_num      (out_res_num),
    .out_res_den      (out_res_den),
    .out_compare_true (out_compare_true),
    .out_error_code   (out_error_code)
  );

endmodule

`default_nettype wire

[tb/rational_arith_unit_checker.sv]
// checker for the rational arithmetic unit: predicts each result and compares it
`timescale 1ns / 1ps
`default_nettype none

module rational_arith_unit_checker
  import raru_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [2:0]         in_op,
  input  wire logic signed [31:0] in_a_num,
  input  wire logic signed [31:0] in_a_den,
  input  wire logic signed [31:0] in_b_num,
  input  wire logic signed [31:0] in_b_den,
  input  wire logic               out_valid,
  input  wire logic signed [31:0] out_res_num,
  input  wire logic signed [31:0] out_res_den,
  input  wire logic               out_compare_true,
  input  wire logic [1:0]         out_error_code,
  output int                      fail_count,
  output int                      pending_count
);

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        cmp;
    logic [1:0]  err;
  } fraction_result_t;

  fraction_result_t pending_results[$];

  // unsigned euclid on magnitudes
  function automatic logic [31:0] mag_gcd(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // reduce p/q and carry the sign on the numerator
  function automatic fraction_result_t reduce_fraction(input logic [31:0] p,
                                                       input logic [31:0] q);
    fraction_result_t r;
    logic [31:0] mp, mq, g, rn, rd;
    logic neg;
    mp = p[31] ? -p : p;
    mq = q[31] ? -q : q;
    g = mag_gcd(mp, mq);
    if (g == 0) g = 1;
    rn = mp / g;
    rd = mq / g;
    neg = p[31] ^ q[31];
    r.num = neg ? -rn : rn;
    r.den = rd;
    r.cmp = 1'b0;
    r.err = ERR_OK;
    return r;
  endfunction

  function automatic fraction_result_t compute_fraction(input logic [2:0] op,
      input logic [31:0] an, input logic [31:0] ad,
      input logic [31:0] bn, input logic [31:0] bd);
    fraction_result_t r;
    logic [31:0] n, d;
    logic build;
    r = '{num: 32'd0, den: 32'd1, cmp: 1'b0, err: ERR_OK};
    n = 0;
    d = 1;
    build = 1'b0;
    case (op)
      OP_MAKE: begin n = an; d = ad; build = 1'b1; end
      OP_ADD:  begin n = an * bd + bn * ad; d = ad * bd; build = 1'b1; end
      OP_SUB:  begin n = an * bd - bn * ad; d = ad * bd; build = 1'b1; end
      OP_MUL:  begin n = an * bn; d = ad * bd; build = 1'b1; end
      OP_DIV: begin
        if (bn == 0) r.err = ERR_DIVZ;
        else begin n = an * bd; d = ad * bn; build = 1'b1; end
      end
      OP_LT: r.cmp = ($signed(an * bd) < $signed(bn * ad));
      OP_EQ: r.cmp = (an == bn) && (ad == bd);
      default: ;
    endcase
    if (build) begin
      if (d == 0) r.err = ERR_ZDEN;
      else r = reduce_fraction(n, d);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  assign pending_count = pending_results.size();

  initial fail_count = 0;

  // predict on accepted transactions, compare on result strobes
  always @(posedge clk) begin
    fraction_result_t want;
    if (rst_n) begin
      if (start && !busy)
        pending_results.push_back(compute_fraction(in_op, in_a_num, in_a_den,
                                                   in_b_num, in_b_den));
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", out_res_num, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_res_num !== want.num) report_mismatch("res_num", out_res_num, want.num);
          if (out_res_den !== want.den) report_mismatch("res_den", out_res_den, want.den);
          if (out_compare_true !== want.cmp)
            report_mismatch("compare_true", out_compare_true, want.cmp);
          if (out_error_code !== want.err)
            report_mismatch("error_code", out_error_code, want.err);
        end
      end
    end
  end

endmodule

`default_nettype wire

[tb/tb_rational_arith_unit_top.sv]
// testbench top for the rational arithmetic unit: stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_rational_arith_unit_top;
  import raru_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int STALL_LIMIT  = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_op = OP_MAKE;
  logic signed [31:0] in_a_num = '0;
  logic signed [31:0] in_a_den = 32'sd1;
  logic signed [31:0] in_b_num = '0;
  logic signed [31:0] in_b_den = 32'sd1;
  logic               out_valid;
  logic signed [31:0] out_res_num;
  logic signed [31:0] out_res_den;
  logic               out_compare_true;
  logic [1:0]         out_error_code;
  int                 fail_count;
  int                 pending_count;
  int                 idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rational_arith_unit_top i_dut (
    .clk, .rst_n, .start, .busy, .in_op, .in_a_num, .in_a_den, .in_b_num, .in_b_den,
    .out_valid, .out_res_num, .out_res_den, .out_compare_true, .out_error_code
  );

  rational_arith_unit_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_op, .in_a_num, .in_a_den, .in_b_num, .in_b_den,
    .out_valid, .out_res_num, .out_res_den, .out_compare_true, .out_error_code,
    .fail_count, .pending_count
  );

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one transaction, held until accepted; start stays high when back to back
  task automatic send_fraction_op(input logic [2:0] op, input logic [31:0] an,
      input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd,
      input bit keep_start);
    in_op    <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (!keep_start) start <= 1'b0;
  endtask

  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
    repeat (n) @(negedge clk);
  endtask

  // random operand: extremes, small values or full-width noise
  function automatic logic [31:0] pick_value(input bit nonzero);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'hffff_ffff;
      3, 4: v = $urandom_range(0, 40) - 20;
      5: v = $urandom_range(0, 2000) - 1000;
      default: v = $urandom;
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  function automatic logic [31:0] pick_den();
    logic [31:0] v;
    v = pick_value(1'b1);
    if ($urandom_range(0, 3) != 0 && v[31]) v = -v;
    if (v == 0) v = 1;
    return v;
  endfunction

  initial begin
    logic [31:0] an, ad, bn, bd;
    logic [2:0]  op;
    bit          back_to_back;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every operation, extremes and each special case
    send_fraction_op(OP_MAKE, 32'd6, 32'd4, 0, 1, 0);
    send_fraction_op(OP_MAKE, 32'd5, 32'hffff_fff6, 0, 1, 0);
    send_fraction_op(OP_MAKE, 32'd0, 32'hffff_fffd, 0, 1, 0);
    send_fraction_op(OP_MAKE, 32'd7, 32'd0, 0, 1, 0);
    send_fraction_op(OP_MAKE, 32'h8000_0000, 32'd1, 0, 1, 0);
    send_fraction_op(OP_MAKE, 32'h8000_0000, 32'hffff_ffff, 0, 1, 0);
    send_fraction_op(OP_MAKE, 32'd1, 32'h8000_0000, 0, 1, 0);
    send_fraction_op(OP_MAKE, 32'h7fff_ffff, 32'h7fff_ffff, 0, 1, 0);
    send_fraction_op(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1);
    send_fraction_op(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 1);
    send_fraction_op(OP_MUL, 32'hffff_fffe, 32'd3, 32'd3, 32'd4, 1);
    send_fraction_op(OP_DIV, 32'd2, 32'd3, 32'hffff_fffc, 32'd9, 0);
    send_fraction_op(OP_DIV, 32'd2, 32'd3, 32'd0, 32'd1, 0);
    send_fraction_op(OP_DIV, 32'd2, 32'd0, 32'd0, 32'd0, 0);
    send_fraction_op(OP_MUL, 32'd1, 32'h0001_0000, 32'd1, 32'h0001_0000, 0);
    send_fraction_op(OP_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1, 0);
    send_fraction_op(OP_LT, 32'd1, 32'd3, 32'd1, 32'd2, 0);
    send_fraction_op(OP_LT, 32'd1, 32'd2, 32'd1, 32'd3, 0);
    send_fraction_op(OP_LT, 32'h8000_0000, 32'd0, 32'd5, 32'd0, 0);
    send_fraction_op(OP_EQ, 32'd3, 32'd4, 32'd3, 32'd4, 0);
    send_fraction_op(OP_EQ, 32'd3, 32'd4, 32'd3, 32'd5, 0);
    send_fraction_op(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_fraction_op(3'd7, 32'h0, 32'h0, 32'h0, 32'h0, 0);

    // hold off until the unit has drained
    wait (pending_count == 0);
    @(negedge clk);

    // random part with bursts and gaps
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      op = 3'($urandom_range(0, 7));
      an = pick_value(1'b0);
      ad = pick_den();
      bn = pick_value(1'b0);
      bd = pick_den();
      if ($urandom_range(0, 19) == 0) ad = 0;
      if ($urandom_range(0, 19) == 0) bd = 0;
      if ($urandom_range(0, 9) == 0) bn = 0;
      if (op == OP_EQ && $urandom_range(0, 1) == 0) begin
        bn = an;
        bd = ad;
      end
      back_to_back = (i % 200) < 40;
      send_fraction_op(op, an, ad, bn, bd, back_to_back && i != RANDOM_ITEMS - 1);
      if (!back_to_back) sender_gap();
      if (i == RANDOM_ITEMS / 2) wait (pending_count == 0);
    end
    start <= 1'b0;

    wait (pending_count == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+design
design/raru_pkg.sv
design/raru_front.sv
design/raru_queue.sv
design/raru_back.sv
design/rational_arith_unit_top.sv
tb/rational_arith_unit_checker.sv
tb/tb_rational_arith_unit_top.sv
